@@ hdl/bvam_pkg.sv @@
// Package for the battery voltage average monitor.
// Holds window sizing, field widths, level codes and register indexes.
// No dependencies.
package bvam_pkg;

   localparam int WINDOW_LEN  = 16;
   localparam int WINDOW_LOG2 = $clog2(WINDOW_LEN);
   localparam int PTR_W       = WINDOW_LOG2;
   localparam int COUNT_W     = $clog2(WINDOW_LEN + 1);
   localparam int SAMPLE_W    = 8;
   localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;

   localparam logic [SAMPLE_W-1:0] ALERT_RESET = 8'd185;
   localparam logic [SAMPLE_W-1:0] STOP_RESET  = 8'd174;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;

   typedef enum logic [1:0] {
      LEVEL_NORMAL = 2'd0,
      LEVEL_LOW    = 2'd1,
      LEVEL_EMPTY  = 2'd2
   } level_type;

   typedef enum logic {
      CSR_ALERT_THRESHOLD = 1'b0,
      CSR_STOP_THRESHOLD  = 1'b1
   } csr_index_type;

endpackage

@@ hdl/bvam_if.sv @@
// Valid/ready channel interfaces for the battery voltage average monitor.
// Depends on bvam_pkg for payload types.
interface bvam_req_if;
   logic                 valid;
   logic                 ready;
   bvam_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bvam_rsp_if;
   logic                 valid;
   logic                 ready;
   bvam_pkg::sample_type average;
   bvam_pkg::level_type  level;

   modport source (output valid, output average, output level, input ready);
   modport sink   (input valid, input average, input level, output ready);
endinterface

@@ hdl/battery_voltage_average_monitor.sv @@
// Battery voltage average monitor: 16-sample moving average with level flags.
// Depends on bvam_pkg and the channel interfaces in bvam_if.sv.
//
// Usage:
//   req_bus carries one 8-bit voltage sample per request (valid/ready).
//   rsp_bus returns, for every request, the held window average and a level
//   (normal, low or empty) measured against the two threshold registers.
//   The csr_ port writes alert_threshold (index 0) and stop_threshold
//   (index 1); write only while no request is in flight.
// Throughput:
//   One request per cycle is sustained while rsp_bus.ready stays high: the
//   window lives in a 16-entry synchronous memory used as a ring, read
//   (oldest sample) and written (new sample) at the same address in the
//   accept cycle, and a running sum absorbs the difference when the
//   request leaves the middle stage.
// Reset:
//   Synchronous, active high. Thresholds return to 185 and 174, the sum,
//   fill count and held average clear. The memory is not cleared: until
//   16 samples have gone in, the fill count stands in for the zero entries.
// Stalls:
//   When rsp_bus.ready is low the response register holds; the pipeline
//   keeps one request in its middle stage and req_bus.ready drops only
//   when both stages are full.
module battery_voltage_average_monitor (
   input  logic                          clock,
   input  logic                          reset,
   bvam_req_if.sink                      req_bus,
   bvam_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  bvam_pkg::csr_index_type       csr_index,
   input  bvam_pkg::sample_type          csr_wdata
);
   import bvam_pkg::*;

   sample_type window_mem [WINDOW_LEN];

   sample_type            alert_ff, stop_ff;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   sum_type               sum_ff, sum_in;
   sample_type            held_ff, held_in;

   // middle stage
   logic                  s1_valid_ff;
   sample_type            s1_sample_ff;
   sample_type            s1_oldest_ff;
   logic                  s1_old_valid_ff;
   logic                  s1_update_ff;

   // response register
   logic                  out_valid_ff;
   sample_type            out_average_ff;
   level_type             out_level_ff;

   logic                  out_free, s1_adv, accept;
   sample_type            oldest;
   sample_type            avg_new;
   level_type             level_new;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.average = out_average_ff;
   assign rsp_bus.level   = out_level_ff;

   // Ring pointer and saturating fill count
   always_comb begin
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (accept) begin
         if (ptr_ff == PTR_W'(WINDOW_LEN - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
         if (count_ff != COUNT_W'(WINDOW_LEN)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // Read-first ring memory: old entry out, new sample in, same address
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_oldest_ff      <= window_mem[ptr_ff];
         window_mem[ptr_ff] <= req_bus.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff    <= req_bus.sample;
         s1_old_valid_ff <= (count_ff == COUNT_W'(WINDOW_LEN));
         s1_update_ff    <= (count_ff >= COUNT_W'(WINDOW_LEN - 1));
      end
   end

   // Running sum and held average
   always_comb begin
      // an entry not yet overwritten still counts as zero
      oldest  = s1_old_valid_ff ? s1_oldest_ff : '0;
      sum_in  = sum_ff;
      held_in = held_ff;
      if (s1_adv) begin
         sum_in = sum_ff + SUM_W'(s1_sample_ff) - SUM_W'(oldest);
         if (s1_update_ff) begin
            held_in = sum_in[SUM_W-1 -: SAMPLE_W];
         end
      end
      avg_new = held_in;
   end

   // Stop threshold is tested first; a zero average reads as normal
   always_comb begin
      if (avg_new == '0) begin
         level_new = LEVEL_NORMAL;
      end else if (avg_new < stop_ff) begin
         level_new = LEVEL_EMPTY;
      end else if (avg_new < alert_ff) begin
         level_new = LEVEL_LOW;
      end else begin
         level_new = LEVEL_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_average_ff <= avg_new;
         out_level_ff   <= level_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alert_ff     <= ALERT_RESET;
         stop_ff      <= STOP_RESET;
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ALERT_THRESHOLD: begin
                  alert_ff <= csr_wdata;
               end
               CSR_STOP_THRESHOLD: begin
                  stop_ff <= csr_wdata;
               end
               default: begin
                  alert_ff <= alert_ff;
               end
            endcase
         end
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         held_ff  <= held_in;
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

endmodule

@@ verif/bvam_tb_pkg.sv @@
// Scoreboard for the battery voltage average monitor testbench.
// Mirrors the sample window, fill count, held average and thresholds.
// Depends on bvam_pkg.
package bvam_tb_pkg;
   import bvam_pkg::*;

   typedef struct packed {
      sample_type average;
      level_type  level;
   } reading_type;

   class level_tracker;
      sample_type  window_q[WINDOW_LEN];
      int unsigned fill;
      sample_type  held;
      sample_type  alert_thr;
      sample_type  stop_thr;
      reading_type due_readings[$];
      int unsigned failures;

      function new();
         foreach (window_q[i]) window_q[i] = '0;
         fill      = 0;
         held      = '0;
         alert_thr = ALERT_RESET;
         stop_thr  = STOP_RESET;
         failures  = 0;
      endfunction

      function void set_threshold(csr_index_type idx, sample_type value);
         case (idx)
            CSR_ALERT_THRESHOLD: alert_thr = value;
            CSR_STOP_THRESHOLD:  stop_thr  = value;
            default: ;
         endcase
      endfunction

      // Zero means still filling (or a window whose average truncates to zero): always normal.
      function level_type grade(sample_type avg);
         if (avg == 0) return LEVEL_NORMAL;
         if (avg < stop_thr) return LEVEL_EMPTY;
         if (avg < alert_thr) return LEVEL_LOW;
         return LEVEL_NORMAL;
      endfunction

      function void note_sample(sample_type s);
         sum_type     total;
         reading_type r;
         for (int i = 0; i < WINDOW_LEN - 1; i++) window_q[i] = window_q[i + 1];
         window_q[WINDOW_LEN - 1] = s;
         if (fill < WINDOW_LEN) fill++;
         if (fill >= WINDOW_LEN) begin
            total = '0;
            foreach (window_q[i]) total = total + sum_type'(window_q[i]);
            held = sample_type'(total / WINDOW_LEN);
         end
         r.average = held;
         r.level   = grade(held);
         due_readings.push_back(r);
      endfunction

      function void check_reading(sample_type avg, level_type lvl);
         reading_type exp_r;
         if (due_readings.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected reading: average %0d level %0d", avg, lvl);
            return;
         end
         exp_r = due_readings.pop_front();
         if (avg !== exp_r.average || lvl !== exp_r.level) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected average %0d level %0d, got average %0d level %0d",
                        exp_r.average, exp_r.level, avg, lvl);
         end
      endfunction
   endclass

endpackage

@@ verif/battery_voltage_average_monitor_tb.sv @@
// Testbench top for the battery voltage average monitor.
// Drives samples and threshold writes, checks every reading against the scoreboard.
// Depends on bvam_pkg, bvam_if.sv, bvam_tb_pkg and the monitor RTL.
module battery_voltage_average_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bvam_pkg::*;
   import bvam_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int          PHASES      = 5;
   localparam int          PHASE_ITEMS = 330;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   sample_type    csr_wdata;

   bvam_req_if req_bus();
   bvam_rsp_if rsp_bus();

   battery_voltage_average_monitor uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   level_tracker tracker = new();

   int unsigned sender_idle_pct;
   int unsigned stall_pct;
   int          drift_base;
   int          zero_run;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Note accepted requests before checking readings at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) tracker.note_sample(req_bus.sample);
         if (rsp_bus.valid && rsp_bus.ready) tracker.check_reading(rsp_bus.average, rsp_bus.level);
      end
   end

   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid and let the last accepted request be noted before waiting on readings.
   task automatic drain_readings();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_readings.size() != 0) @(posedge clock);
   endtask

   // Leave the write enable high; the caller drops it after the last write.
   task automatic write_threshold(input csr_index_type idx, input sample_type value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      tracker.set_threshold(idx, value);
      @(posedge clock);
   endtask

   // Slowly drifting level with noise, occasional wild samples and zero runs.
   function automatic sample_type draw_sample();
      int r;
      int v;
      if (zero_run > 0) begin
         zero_run--;
         return '0;
      end
      r = $urandom_range(199);
      if (r == 0) begin
         zero_run = 17 + $urandom_range(8);
         return '0;
      end
      if (r < 20) return sample_type'($urandom_range(255));
      if (r < 30) drift_base = $urandom_range(255);
      else drift_base = drift_base + $urandom_range(6) - 3;
      if (drift_base < 0) drift_base = 0;
      if (drift_base > 255) drift_base = 255;
      v = drift_base + $urandom_range(24) - 12;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return sample_type'(v);
   endfunction

   initial begin
      sample_type directed_q[$];
      sample_type alert_v;
      sample_type stop_v;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.sample  <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_ALERT_THRESHOLD;
      csr_wdata       <= '0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      drift_base      = 128;
      zero_run        = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill with zeros so the full window averages to zero, then hit the extremes.
      repeat (16) directed_q.push_back(8'd0);
      directed_q.push_back(8'd255);
      directed_q.push_back(8'd1);
      directed_q.push_back(8'd128);
      repeat (6) directed_q.push_back(8'd255);
      foreach (directed_q[i]) send_sample(directed_q[i]);
      drain_readings();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin alert_v = 8'd0;   stop_v = 8'd0;   end
            1: begin alert_v = 8'd255; stop_v = 8'd255; end
            2: begin alert_v = 8'd90;  stop_v = 8'd200; end
            3: begin
               alert_v = sample_type'($urandom_range(255));
               stop_v  = sample_type'($urandom_range(255));
            end
            default: begin alert_v = ALERT_RESET; stop_v = STOP_RESET; end
         endcase
         write_threshold(CSR_ALERT_THRESHOLD, alert_v);
         write_threshold(CSR_STOP_THRESHOLD, stop_v);
         csr_wr_en <= 1'b0;
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 81; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 81; end
            default: begin sender_idle_pct = 9; stall_pct = 9; end
         endcase
         repeat (PHASE_ITEMS) send_sample(draw_sample());
         drain_readings();
      end

      repeat (4) @(posedge clock);
      if (tracker.failures == 0 && tracker.due_readings.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
